/* rtl/gregorian_date_arithmetic_unit_defines.svh */
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit: assertion macros
// Concurrent assertion helpers for the checks in the top module of this block.
// They expect clk and arst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ARITHMETIC_UNIT_DEFINES_SVH
`define GREGORIAN_DATE_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GDAU_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GDAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/gdau_pkg.sv */
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit: shared package
// Field widths, word types and calendar tables used by all pipeline stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gdau_pkg;

	localparam int DAY_W    = 5;
	localparam int MONTH_W  = 4;
	localparam int YEAR_W   = 14;
	localparam int ORD_W    = 22;
	localparam int WEEK_W   = 6;
	localparam int DOY_W    = 9;
	localparam int Q100_W   = 8;

	// Division of a year by one hundred through a reciprocal multiply.
	localparam int RECIP_100     = 5243;
	localparam int RECIP_SHIFT   = 19;
	localparam int RECIP_PROD_W  = YEAR_W + 13;

	// Division of the day of year by seven through a reciprocal multiply.
	localparam int RECIP_7       = 293;
	localparam int RECIP_7_SHIFT = 11;
	localparam int WEEK_PROD_W   = DOY_W + 1 + 9;

	localparam int DIV_CENTURY   = 100;
	localparam int DAYS_PER_YEAR = 365;
	localparam int DAYS_PER_WEEK = 7;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
	localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;

	typedef struct packed {
		logic [DAY_W-1:0]   first_day;
		logic [MONTH_W-1:0] first_month;
		logic [YEAR_W-1:0]  first_year;
		logic [DAY_W-1:0]   second_day;
		logic [MONTH_W-1:0] second_month;
		logic [YEAR_W-1:0]  second_year;
	} dates_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [DAY_W-1:0]   next_day;
		logic [MONTH_W-1:0] next_month;
		logic [YEAR_W-1:0]  next_year;
		logic               next_overflow;
		logic [DAY_W-1:0]   prev_day;
		logic [MONTH_W-1:0] prev_month;
		logic [YEAR_W-1:0]  prev_year;
		logic               prev_underflow;
		logic [ORD_W-1:0]   day_ordinal;
		logic [WEEK_W-1:0]  week_of_year;
		logic [ORD_W-1:0]   days_between;
	} result_t;

	// Decoded view of one date, produced by the second pipeline stage.
	typedef struct packed {
		logic               ok;
		logic               leap;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [DAY_W-1:0]   mlen;
		logic [DOY_W-1:0]   doy;
		logic [YEAR_W-1:0]  pyear;
		logic [Q100_W-1:0]  p100;
	} date_info_t;

	// Neighbor dates and week number of the first date.
	typedef struct packed {
		logic [DAY_W-1:0]   next_day;
		logic [MONTH_W-1:0] next_month;
		logic [YEAR_W-1:0]  next_year;
		logic               next_overflow;
		logic [DAY_W-1:0]   prev_day;
		logic [MONTH_W-1:0] prev_month;
		logic [YEAR_W-1:0]  prev_year;
		logic               prev_underflow;
		logic [WEEK_W-1:0]  week;
	} neighbor_t;

	// Length of a month; months outside 1..12 give zero.
	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
		input logic leap);
		logic [DAY_W-1:0] n;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
			4'd2:                                       n = leap ? 5'd29 : 5'd28;
			default:                                    n = 5'd0;
		endcase
		return n;
	endfunction

	// Days before the first of a month in a common year.
	function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] month);
		logic [DOY_W-1:0] n;
		case (month)
			4'd2:    n = 9'd31;
			4'd3:    n = 9'd59;
			4'd4:    n = 9'd90;
			4'd5:    n = 9'd120;
			4'd6:    n = 9'd151;
			4'd7:    n = 9'd181;
			4'd8:    n = 9'd212;
			4'd9:    n = 9'd243;
			4'd10:   n = 9'd273;
			4'd11:   n = 9'd304;
			4'd12:   n = 9'd334;
			default: n = 9'd0;
		endcase
		return n;
	endfunction

endpackage

`default_nettype wire

/* rtl/gregorian_date_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit
// Four-stage pipeline that checks two dates and computes the neighbors,
// ordinal day, week of year of the first date and the distance between them.
// ----------------------------------------------------------------------------
// A word (a pair of dates) is taken at every rising edge where start is high;
// busy is tied low because the pipeline never holds anything back, so one
// word can be issued in every cycle. Done rises once the word has passed
// through the result register and stays high for one cycle. The receiver
// cannot stall the unit, so a result that is not captured in that cycle is
// gone. The four register stages are the century reciprocal multiply, the
// calendar decode, the ordinal and week arithmetic, and the final
// difference with the result register. There is no state between words
// and nothing to configure.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_arithmetic_unit #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  gdau_pkg::dates_t operands,
	output logic             done,
	output gdau_pkg::result_t result
);
	import gdau_pkg::*;

`include "gregorian_date_arithmetic_unit_defines.svh"

	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic       accept;
	date_info_t info1, info2;
	neighbor_t  nbr1;
	logic [ORD_W-1:0] ord1, ord2;
	logic       ok1, ok2;
	logic [ORD_W-1:0] diff;
	result_t    result_d;
	result_t    result_s4;
	logic       pipe_idle;
	logic       first_bad;
	logic       either_bad;
	logic       first_clear;
	logic       first_set;
	logic       dist_clear;

	// The unit never refuses a word.
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// Valid bits walk alongside the data; each stage only loads when its
	// predecessor held a word, which keeps idle stages from toggling.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Stages one and two: both dates are decoded by identical units.
	gdau_date_decode #(
		.MAX_YEAR(MAX_YEAR)
	) u_decode_first (
		.clk   (clk),
		.en_s1 (accept),
		.en_s2 (valid_s1),
		.day   (operands.first_day),
		.month (operands.first_month),
		.year  (operands.first_year),
		.info  (info1)
	);

	gdau_date_decode #(
		.MAX_YEAR(MAX_YEAR)
	) u_decode_second (
		.clk   (clk),
		.en_s1 (accept),
		.en_s2 (valid_s1),
		.day   (operands.second_day),
		.month (operands.second_month),
		.year  (operands.second_year),
		.info  (info2)
	);

	// Stage three: ordinal counts for both dates, neighbors for the first.
	gdau_ordinal u_ordinal_first (
		.clk  (clk),
		.en   (valid_s2),
		.info (info1),
		.ord  (ord1),
		.ok   (ok1)
	);

	gdau_ordinal u_ordinal_second (
		.clk  (clk),
		.en   (valid_s2),
		.info (info2),
		.ord  (ord2),
		.ok   (ok2)
	);

	gdau_neighbor #(
		.MAX_YEAR(MAX_YEAR)
	) u_neighbor (
		.clk  (clk),
		.en   (valid_s2),
		.info (info1),
		.nbr  (nbr1)
	);

	// Stage four: distance between the dates and the gated result word.
	// Any invalid date forces the distance to zero, and an invalid first
	// date also clears the ordinal; the neighbor fields arrive already
	// cleared from stage three.
	always_comb begin
		diff = (ord1 >= ord2) ? (ord1 - ord2) : (ord2 - ord1);

		result_d.status         = {!ok2, !ok1};
		result_d.next_day       = nbr1.next_day;
		result_d.next_month     = nbr1.next_month;
		result_d.next_year      = nbr1.next_year;
		result_d.next_overflow  = nbr1.next_overflow;
		result_d.prev_day       = nbr1.prev_day;
		result_d.prev_month     = nbr1.prev_month;
		result_d.prev_year      = nbr1.prev_year;
		result_d.prev_underflow = nbr1.prev_underflow;
		result_d.day_ordinal    = ok1 ? ord1 : '0;
		result_d.week_of_year   = nbr1.week;
		result_d.days_between   = (ok1 && ok2) ? diff : '0;
	end

	always_ff @(posedge clk) begin
		if (valid_s3) begin
			result_s4 <= result_d;
		end
	end

	assign done   = valid_s4;
	assign result = result_s4;

	// Conditions on the result word used by the checks below.
	assign pipe_idle   = !valid_s1 && !valid_s2 && !valid_s3;
	assign first_bad   = result.status[0];
	assign either_bad  = (result.status != 2'b00);
	assign first_clear = (result.day_ordinal == '0) && (result.week_of_year == '0)
		&& !result.next_overflow && !result.prev_underflow;
	assign first_set   = (result.day_ordinal != '0) && (result.week_of_year != '0);
	assign dist_clear  = (result.days_between == '0);

	// Every result traces back to a word that start presented at the input.
	`GDAU_ASSERT_IMP(a_latency, done, $past(start, 4), "result without a word four cycles back")

	// With nothing in the first three stages, no result can follow.
	`GDAU_ASSERT_NEXT(a_drain, pipe_idle, !done, "result from an empty pipe")

	// An invalid first date clears its derived fields.
	`GDAU_ASSERT_IMP(a_first_bad, done && first_bad, first_clear, "invalid first date not cleared")

	// Any invalid date clears the distance.
	`GDAU_ASSERT_IMP(a_between_bad, done && either_bad, dist_clear, "distance with an invalid date")

	// A valid first date always has a nonzero ordinal and week.
	`GDAU_ASSERT_IMP(a_first_good, done && !first_bad, first_set, "zero ordinal or week")

endmodule

`default_nettype wire

/* rtl/gdau_date_decode.sv */
// ----------------------------------------------------------------------------
// Date decoder
// Stages one and two for one date: century quotient, leap rule, validity,
// month length, day of year and the year terms used by the ordinal count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdau_date_decode #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                         clk,
	input  logic                         en_s1,
	input  logic                         en_s2,
	input  logic [gdau_pkg::DAY_W-1:0]   day,
	input  logic [gdau_pkg::MONTH_W-1:0] month,
	input  logic [gdau_pkg::YEAR_W-1:0]  year,
	output gdau_pkg::date_info_t         info
);
	import gdau_pkg::*;

	logic [DAY_W-1:0]        day_s1;
	logic [MONTH_W-1:0]      month_s1;
	logic [YEAR_W-1:0]       year_s1;
	logic [Q100_W-1:0]       q100_s1;
	logic [RECIP_PROD_W-1:0] q_prod;
	logic [YEAR_W-1:0]       rem100;
	logic                    rem_zero;
	logic                    leap;
	logic [DAY_W-1:0]        mlen;
	logic                    year_ok, month_ok, day_ok;
	date_info_t              info_d;
	date_info_t              info_s2;

	assign q_prod = RECIP_PROD_W'(year) * RECIP_PROD_W'(RECIP_100);

	always_ff @(posedge clk) begin
		if (en_s1) begin
			day_s1   <= day;
			month_s1 <= month;
			year_s1  <= year;
			q100_s1  <= q_prod[RECIP_SHIFT +: Q100_W];
		end
	end

	always_comb begin
		rem100   = year_s1 - YEAR_W'(q100_s1) * YEAR_W'(DIV_CENTURY);
		rem_zero = (rem100 == '0);
		// Divisible by four, and either not a century or a century divisible by four.
		leap     = (year_s1[1:0] == 2'b00) && (!rem_zero || (q100_s1[1:0] == 2'b00));
		mlen     = month_len(month_s1, leap);
		year_ok  = (year_s1 != '0) && (year_s1 <= YEAR_W'(MAX_YEAR));
		month_ok = (month_s1 >= MONTH_JAN) && (month_s1 <= MONTH_DEC);
		day_ok   = (day_s1 != '0) && (day_s1 <= mlen);

		info_d.ok    = year_ok && month_ok && day_ok;
		info_d.leap  = leap;
		info_d.day   = day_s1;
		info_d.month = month_s1;
		info_d.year  = year_s1;
		info_d.mlen  = mlen;
		info_d.doy   = month_start(month_s1) + DOY_W'(day_s1)
			+ DOY_W'((month_s1 > MONTH_FEB) && leap);
		info_d.pyear = year_s1 - YEAR_W'(1);
		// Centuries of the previous year drop by one when this year is a century.
		info_d.p100  = q100_s1 - Q100_W'(rem_zero);
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			info_s2 <= info_d;
		end
	end

	assign info = info_s2;

endmodule

`default_nettype wire

/* rtl/gdau_ordinal.sv */
// ----------------------------------------------------------------------------
// Ordinal day counter
// Stage three for one date: days from the first day of year one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdau_ordinal (
	input  logic                       clk,
	input  logic                       en,
	input  gdau_pkg::date_info_t       info,
	output logic [gdau_pkg::ORD_W-1:0] ord,
	output logic                       ok
);
	import gdau_pkg::*;

	localparam int SUM_W = ORD_W + 1;

	logic [SUM_W-1:0] sum;
	logic [ORD_W-1:0] ord_s3;
	logic             ok_s3;

	assign sum = SUM_W'(info.pyear) * SUM_W'(DAYS_PER_YEAR)
		+ SUM_W'(info.pyear >> 2)
		- SUM_W'(info.p100)
		+ SUM_W'(info.p100 >> 2)
		+ SUM_W'(info.doy);

	always_ff @(posedge clk) begin
		if (en) begin
			ord_s3 <= sum[ORD_W-1:0];
			ok_s3  <= info.ok;
		end
	end

	assign ord = ord_s3;
	assign ok  = ok_s3;

endmodule

`default_nettype wire

/* rtl/gdau_neighbor.sv */
// ----------------------------------------------------------------------------
// Neighbor date and week stage
// Stage three for the first date: following day, preceding day and week of
// the year, all cleared when the date is invalid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gdau_neighbor #(
	parameter int unsigned MAX_YEAR = 9999
) (
	input  logic                 clk,
	input  logic                 en,
	input  gdau_pkg::date_info_t info,
	output gdau_pkg::neighbor_t  nbr
);
	import gdau_pkg::*;

	logic [WEEK_PROD_W-1:0] week_prod;
	logic [MONTH_W-1:0]     month_dec;
	neighbor_t              nbr_d;
	neighbor_t              nbr_s3;

	assign month_dec = info.month - MONTH_W'(1);
	assign week_prod = WEEK_PROD_W'(info.doy + DOY_W'(DAYS_PER_WEEK - 1))
		* WEEK_PROD_W'(RECIP_7);

	always_comb begin
		nbr_d = '0;
		if (info.ok) begin
			if (info.day < info.mlen) begin
				nbr_d.next_day   = info.day + DAY_W'(1);
				nbr_d.next_month = info.month;
				nbr_d.next_year  = info.year;
			end else if (info.month < MONTH_DEC) begin
				nbr_d.next_day   = DAY_FIRST;
				nbr_d.next_month = info.month + MONTH_W'(1);
				nbr_d.next_year  = info.year;
			end else if (info.year < YEAR_W'(MAX_YEAR)) begin
				nbr_d.next_day   = DAY_FIRST;
				nbr_d.next_month = MONTH_JAN;
				nbr_d.next_year  = info.year + YEAR_W'(1);
			end else begin
				nbr_d.next_overflow = 1'b1;
			end

			if (info.day > DAY_FIRST) begin
				nbr_d.prev_day   = info.day - DAY_W'(1);
				nbr_d.prev_month = info.month;
				nbr_d.prev_year  = info.year;
			end else if (info.month > MONTH_JAN) begin
				nbr_d.prev_day   = month_len(month_dec, info.leap);
				nbr_d.prev_month = month_dec;
				nbr_d.prev_year  = info.year;
			end else if (info.year > YEAR_W'(1)) begin
				nbr_d.prev_day   = DAY_LAST_DEC;
				nbr_d.prev_month = MONTH_DEC;
				nbr_d.prev_year  = info.year - YEAR_W'(1);
			end else begin
				nbr_d.prev_underflow = 1'b1;
			end

			nbr_d.week = week_prod[RECIP_7_SHIFT +: WEEK_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nbr_s3 <= nbr_d;
		end
	end

	assign nbr = nbr_s3;

endmodule

`default_nettype wire

/* tb/gregorian_date_arithmetic_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian date arithmetic unit: self-checking testbench
// Sends pairs of dates to the unit in random bursts. Each word that the unit
// takes is run through a calendar predictor of its own. The result words that
// come back are compared field by field, in order, with the predicted ones.
// ----------------------------------------------------------------------------

module gregorian_date_arithmetic_unit_tb;

	import gdau_pkg::*;

	localparam int unsigned LAST_YEAR = 9999;

	// The unit has four register stages. The tail wait at the end scales with this depth.
	localparam int PIPE_DEPTH = 4;

	// The status field has one bit for each date that fails the calendar check.
	localparam logic [1:0] FIRST_BAD  = 2'b01;
	localparam logic [1:0] SECOND_BAD = 2'b10;

	// One date, used when building stimulus.
	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} cal_date_t;

	// A pending word. When settle is set, the driver holds this word back until
	// every result already owed has come out of the pipeline.
	typedef struct packed {
		logic   settle;
		dates_t dates;
	} word_req_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	dates_t  operands = '0;
	logic    done;
	result_t result;

	word_req_t word_q[$];     // words waiting to be sent
	result_t   outcome_q[$];  // predicted results of the words taken so far
	int        mismatch_count = 0;
	int        burst_left = 0;
	int        gap_left = 0;
	word_req_t next_req;
	result_t   want;

	gregorian_date_arithmetic_unit #(
		.MAX_YEAR(LAST_YEAR)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operands(operands),
		.done(done),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Calendar predictor
	// ------------------------------------------------------------------------

	// A year divisible by 400 is leap. Any other year divisible by 100 is not.
	// Any other year divisible by 4 is leap.
	function automatic bit leap_year(input int unsigned y);
		return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		case (m)
			1, 3, 5, 7, 8, 10, 12: return 31;
			4, 6, 9, 11:           return 30;
			2:                     return leap_year(y) ? 29 : 28;
			default:               return 0;
		endcase
	endfunction

	function automatic bit date_valid(input int unsigned d, input int unsigned m,
		input int unsigned y);
		return (y >= 1) && (y <= LAST_YEAR) && (m >= 1) && (m <= 12)
			&& (d >= 1) && (d <= days_in_month(m, y));
	endfunction

	// Day of the year, found by adding up the months that have already passed.
	function automatic int unsigned year_day(input int unsigned d, input int unsigned m,
		input int unsigned y);
		int unsigned n;
		n = d;
		for (int k = 1; k < m; k++) n += days_in_month(k, y);
		return n;
	endfunction

	// Day count from 01.01.0001, which is day one.
	function automatic int unsigned day_count(input int unsigned d, input int unsigned m,
		input int unsigned y);
		int unsigned p;
		p = y - 1;
		return 365 * p + p / 4 - p / 100 + p / 400 + year_day(d, m, y);
	endfunction

	function automatic result_t date_outcome(input dates_t w);
		result_t     r;
		int unsigned d1, m1, y1, d2, m2, y2;
		int unsigned c1, c2;
		bit          ok1, ok2;
		r   = '0;
		d1  = w.first_day;
		m1  = w.first_month;
		y1  = w.first_year;
		d2  = w.second_day;
		m2  = w.second_month;
		y2  = w.second_year;
		ok1 = date_valid(d1, m1, y1);
		ok2 = date_valid(d2, m2, y2);
		r.status = (ok1 ? 2'b00 : FIRST_BAD) | (ok2 ? 2'b00 : SECOND_BAD);
		// Every field but status stays zero when the first date is invalid.
		if (ok1) begin
			if (d1 < days_in_month(m1, y1)) begin
				r.next_day   = DAY_W'(d1 + 1);
				r.next_month = MONTH_W'(m1);
				r.next_year  = YEAR_W'(y1);
			end else if (m1 < MONTH_DEC) begin
				r.next_day   = DAY_FIRST;
				r.next_month = MONTH_W'(m1 + 1);
				r.next_year  = YEAR_W'(y1);
			end else if (y1 < LAST_YEAR) begin
				r.next_day   = DAY_FIRST;
				r.next_month = MONTH_JAN;
				r.next_year  = YEAR_W'(y1 + 1);
			end else begin
				r.next_overflow = 1'b1;
			end
			if (d1 > 1) begin
				r.prev_day   = DAY_W'(d1 - 1);
				r.prev_month = MONTH_W'(m1);
				r.prev_year  = YEAR_W'(y1);
			end else if (m1 > MONTH_JAN) begin
				r.prev_day   = DAY_W'(days_in_month(m1 - 1, y1));
				r.prev_month = MONTH_W'(m1 - 1);
				r.prev_year  = YEAR_W'(y1);
			end else if (y1 > 1) begin
				r.prev_day   = DAY_LAST_DEC;
				r.prev_month = MONTH_DEC;
				r.prev_year  = YEAR_W'(y1 - 1);
			end else begin
				r.prev_underflow = 1'b1;
			end
			c1 = day_count(d1, m1, y1);
			r.day_ordinal  = ORD_W'(c1);
			r.week_of_year = WEEK_W'((year_day(d1, m1, y1) + 6) / 7);
			if (ok2) begin
				c2 = day_count(d2, m2, y2);
				r.days_between = ORD_W'(c1 >= c2 ? c1 - c2 : c2 - c1);
			end
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic dates_t date_pair(input int unsigned d1, input int unsigned m1,
		input int unsigned y1, input int unsigned d2, input int unsigned m2,
		input int unsigned y2);
		dates_t w;
		w.first_day    = DAY_W'(d1);
		w.first_month  = MONTH_W'(m1);
		w.first_year   = YEAR_W'(y1);
		w.second_day   = DAY_W'(d2);
		w.second_month = MONTH_W'(m2);
		w.second_year  = YEAR_W'(y2);
		return w;
	endfunction

	// A valid date. The year is drawn now and then from the leap and calendar
	// edges, and the day leans toward the first and last of the month.
	function automatic cal_date_t valid_date();
		cal_date_t   c;
		int unsigned y, m, len;
		if ($urandom_range(0, 3) == 0) begin
			case ($urandom_range(0, 8))
				0:       y = 1;
				1:       y = 2;
				2:       y = 4;
				3:       y = 100;
				4:       y = 400;
				5:       y = 1900;
				6:       y = 2000;
				7:       y = LAST_YEAR - 1;
				default: y = LAST_YEAR;
			endcase
		end else begin
			y = $urandom_range(1, LAST_YEAR);
		end
		m   = $urandom_range(1, 12);
		len = days_in_month(m, y);
		c.year  = YEAR_W'(y);
		c.month = MONTH_W'(m);
		case ($urandom_range(0, 5))
			0:       c.day = DAY_FIRST;
			1:       c.day = DAY_W'(len);
			default: c.day = DAY_W'($urandom_range(1, len));
		endcase
		return c;
	endfunction

	// A valid date with one field pushed out of range, or plain noise.
	function automatic cal_date_t broken_date();
		cal_date_t c;
		c = valid_date();
		case ($urandom_range(0, 3))
			0: begin
				if (c.day < 31) c.day = DAY_W'(days_in_month(c.month, c.year) + 1);
				else c.day = '0;
			end
			1: c.month = ($urandom_range(0, 1) == 0) ? MONTH_W'(0) : MONTH_W'($urandom_range(13, 15));
			2: c.year = ($urandom_range(0, 1) == 0) ? YEAR_W'(0)
				: YEAR_W'($urandom_range(LAST_YEAR + 1, 16383));
			default: c = cal_date_t'($urandom);
		endcase
		return c;
	endfunction

	task automatic queue_word(input dates_t w, input bit settle);
		word_req_t req;
		req.settle = settle;
		req.dates  = w;
		word_q.push_back(req);
	endtask

	task automatic check_field(input string name, input int unsigned expected_val,
		input int unsigned actual_val);
		if (expected_val != actual_val) begin
			$error("%s: expected %0d, got %0d", name, expected_val, actual_val);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// Driver
	// ------------------------------------------------------------------------
	// The driver sends words in bursts of random length with random gaps between
	// them. Some bursts are long, so stretches with no gap at all also occur.
	// A new word goes out only when the port is free: either nothing is offered,
	// or the word on the port is taken at this edge.
	always @(posedge clk) begin
		if (arst_n && (!start || !busy)) begin
			if (gap_left > 0) begin
				start <= 1'b0;
				gap_left--;
			end else if (word_q.size() == 0) begin
				start <= 1'b0;
			end else if (word_q[0].settle && (start || outcome_q.size() != 0)) begin
				// Wait until the pipeline has emptied. The word taken at this edge
				// is still owed, so start must also be low before the word goes out.
				start <= 1'b0;
			end else begin
				next_req = word_q.pop_front();
				operands <= next_req.dates;
				start <= 1'b1;
				if (burst_left == 0)
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
						: $urandom_range(1, 12);
				burst_left--;
				if (burst_left == 0) gap_left = $urandom_range(1, 6);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor
	// ------------------------------------------------------------------------
	// Each word taken at an edge gets its prediction here, from the values that
	// the port held at that edge. Each result marked by done is compared with
	// the oldest prediction still waiting.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) outcome_q.push_back(date_outcome(operands));
			if (done) begin
				if (outcome_q.size() == 0) begin
					$error("result word with no word outstanding");
					mismatch_count++;
				end else begin
					want = outcome_q.pop_front();
					check_field("status", want.status, result.status);
					check_field("next_day", want.next_day, result.next_day);
					check_field("next_month", want.next_month, result.next_month);
					check_field("next_year", want.next_year, result.next_year);
					check_field("next_overflow", want.next_overflow, result.next_overflow);
					check_field("prev_day", want.prev_day, result.prev_day);
					check_field("prev_month", want.prev_month, result.prev_month);
					check_field("prev_year", want.prev_year, result.prev_year);
					check_field("prev_underflow", want.prev_underflow, result.prev_underflow);
					check_field("day_ordinal", want.day_ordinal, result.day_ordinal);
					check_field("week_of_year", want.week_of_year, result.week_of_year);
					check_field("days_between", want.days_between, result.days_between);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		cal_date_t a, b;
		int        pick;

		// Directed words: both ends of the calendar, the leap rules, month and
		// year rollover in both directions, the last week of the year, and
		// invalid dates on either side.
		queue_word(date_pair(1, 1, 1, 31, 12, LAST_YEAR), 1'b0);
		queue_word(date_pair(31, 12, LAST_YEAR, 1, 1, 1), 1'b0);
		queue_word(date_pair(1, 1, 1, 1, 1, 1), 1'b0);
		queue_word(date_pair(29, 2, 2000, 28, 2, 1900), 1'b0);
		queue_word(date_pair(29, 2, 1900, 1, 3, 1900), 1'b0);
		queue_word(date_pair(15, 6, 2024, 29, 2, 2100), 1'b0);
		queue_word(date_pair(0, 0, 0, 31, 15, 16383), 1'b0);
		queue_word(date_pair(31, 15, 16383, 0, 0, 0), 1'b0);
		queue_word(date_pair(31, 12, 2023, 1, 1, 2024), 1'b0);
		queue_word(date_pair(1, 3, 2024, 29, 2, 2024), 1'b0);
		queue_word(date_pair(1, 3, 2023, 1, 3, 2024), 1'b0);
		queue_word(date_pair(29, 2, 2024, 28, 2, 2023), 1'b0);
		queue_word(date_pair(31, 1, 1999, 1, 1, 2000), 1'b0);
		queue_word(date_pair(1, 5, 400, 1, 5, 400), 1'b0);
		queue_word(date_pair(1, 1, 2, 31, 12, 1), 1'b0);
		queue_word(date_pair(31, 12, 2000, 31, 12, 1999), 1'b0);
		queue_word(date_pair(31, 12, 1999, 7, 1, 1999), 1'b0);
		queue_word(date_pair(8, 1, 1999, 30, 2, 2000), 1'b0);
		queue_word(date_pair(31, 4, 2001, 30, 4, 2001), 1'b0);
		queue_word(date_pair(1, 13, 2001, 1, 12, 10000), 1'b0);
		queue_word(date_pair(1, 1, 10000, 31, 12, LAST_YEAR), 1'b0);
		queue_word(date_pair(30, 12, LAST_YEAR, 2, 1, 1), 1'b0);
		queue_word(date_pair(1, 1, LAST_YEAR, 29, 2, 4), 1'b0);

		// Random words: mostly valid pairs, with broken dates and noise mixed in.
		// Now and then the sender waits for the pipeline to empty before going on.
		for (int i = 0; i < 1330; i++) begin
			pick = $urandom_range(0, 9);
			a = (pick == 7 || pick == 9) ? broken_date() : valid_date();
			b = (pick == 8 || pick == 9) ? broken_date() : valid_date();
			queue_word(date_pair(a.day, a.month, a.year, b.day, b.month, b.year),
				(i % 400) == 399);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (word_q.size() != 0 || start || outcome_q.size() != 0) @(posedge clk);
		// Any stray result would show up during this tail wait.
		repeat (2 * PIPE_DEPTH) @(posedge clk);
		// A prediction still waiting here is a result that never came.
		if (mismatch_count == 0 && outcome_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Timeout, far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
